// ===== rtl/mtdd_pkg.sv =====
package mtdd_pkg;

	// Command codes of the input channel.
	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_LOAD    = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	// Scan phases: each lit phase is followed by a blanking phase.
	typedef enum logic [2:0] {
		PH_ONES     = 3'd0,
		PH_BLANK1   = 3'd1,
		PH_TENS     = 3'd2,
		PH_BLANK2   = 3'd3,
		PH_HUNDREDS = 3'd4,
		PH_BLANK3   = 3'd5
	} phase_t;

	localparam logic [7:0] ON_TIME_RST  = 8'd9;
	localparam logic [7:0] OFF_TIME_RST = 8'd1;

	localparam logic [0:0] REG_ON_TIME  = 1'b0;
	localparam logic [0:0] REG_OFF_TIME = 1'b1;

	// Rounded-up reciprocal of 100000/97665 in 0.32 fixed point; the error is far
	// below the smallest fractional gap of reading*0.97665 over ten-bit readings.
	localparam logic [31:0] VOLT_MUL =
		32'((64'd97665 * (64'd1 << 32) + 64'd99999) / 64'd100000);

	localparam int unsigned VOLT_SHIFT = 32;

	typedef struct packed {
		cmd_t       command;
		logic [9:0] volts;
		logic [3:0] ones_digit;
		logic [3:0] tens_digit;
		logic [3:0] hundreds_digit;
	} item_t;

	typedef struct packed {
		logic [1:0] digit_select;
		logic [6:0] segments;
	} res_t;

	function automatic logic [6:0] seg_shape(input logic [3:0] d);
		logic [6:0] s;
		case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/mtdd_scan.sv =====
module mtdd_scan (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  mtdd_pkg::item_t item,
	input  logic [7:0]      on_time,
	input  logic [7:0]      off_time,
	output mtdd_pkg::res_t  result
);

	mtdd_pkg::phase_t phase_q;
	mtdd_pkg::phase_t phase_d;
	logic [7:0]       lit_q;
	logic [7:0]       blank_q;
	logic [3:0]       ones_q;
	logic [3:0]       tens_q;
	logic [3:0]       hund_q;
	logic [6:0]       last_seg_q;

	logic             is_lit;
	logic [1:0]       which;
	logic [3:0]       cur_digit;
	logic [6:0]       seg_new;
	logic [7:0]       lit_dec;
	logic [7:0]       blank_dec;

	// Decimal split of the volts value by reciprocal multiplication.
	logic [17:0]      tenths_prod;
	logic [6:0]       div10;
	logic [15:0]      hund_prod;
	logic [3:0]       conv_hund;
	logic [9:0]       ones_full;
	logic [6:0]       tens_full;

	assign tenths_prod = 18'(item.volts) * 18'd205;
	assign div10       = tenths_prod[17:11];
	assign hund_prod   = 16'(item.volts) * 16'd41;
	assign conv_hund   = hund_prod[15:12];
	assign ones_full   = item.volts - 10'(div10) * 10'd10;
	assign tens_full   = div10 - 7'(conv_hund) * 7'd10;

	assign lit_dec   = lit_q - 8'd1;
	assign blank_dec = blank_q - 8'd1;

	// Output decode of the phase; the unused codes behave as the ones phase.
	always_comb begin
		is_lit = 1'b1;
		which  = 2'd0;
		unique case (phase_q) inside
			mtdd_pkg::PH_ONES: begin
				is_lit = 1'b1;
				which  = 2'd0;
			end
			mtdd_pkg::PH_TENS: begin
				is_lit = 1'b1;
				which  = 2'd1;
			end
			mtdd_pkg::PH_HUNDREDS: begin
				is_lit = 1'b1;
				which  = 2'd2;
			end
			mtdd_pkg::PH_BLANK1, mtdd_pkg::PH_BLANK2, mtdd_pkg::PH_BLANK3: begin
				is_lit = 1'b0;
				which  = 2'd0;
			end
			default: begin
				is_lit = 1'b1;
				which  = 2'd0;
			end
		endcase
	end

	always_comb begin
		case (which)
			2'd1:    cur_digit = tens_q;
			2'd2:    cur_digit = hund_q;
			default: cur_digit = ones_q;
		endcase
		// A digit above nine leaves the previous pattern on the bus.
		seg_new = (cur_digit < 4'd10) ? mtdd_pkg::seg_shape(cur_digit) : last_seg_q;
		result.digit_select = is_lit ? (which + 2'd1) : 2'd0;
		result.segments     = is_lit ? seg_new : last_seg_q;
	end

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			mtdd_pkg::PH_ONES:
				phase_d = (lit_dec == 8'd0) ? mtdd_pkg::PH_BLANK1 : mtdd_pkg::PH_ONES;
			mtdd_pkg::PH_BLANK1:
				phase_d = (blank_dec == 8'd0) ? mtdd_pkg::PH_TENS : mtdd_pkg::PH_BLANK1;
			mtdd_pkg::PH_TENS:
				phase_d = (lit_dec == 8'd0) ? mtdd_pkg::PH_BLANK2 : mtdd_pkg::PH_TENS;
			mtdd_pkg::PH_BLANK2:
				phase_d = (blank_dec == 8'd0) ? mtdd_pkg::PH_HUNDREDS : mtdd_pkg::PH_BLANK2;
			mtdd_pkg::PH_HUNDREDS:
				phase_d = (lit_dec == 8'd0) ? mtdd_pkg::PH_BLANK3 : mtdd_pkg::PH_HUNDREDS;
			mtdd_pkg::PH_BLANK3:
				phase_d = (blank_dec == 8'd0) ? mtdd_pkg::PH_ONES : mtdd_pkg::PH_BLANK3;
			default:
				phase_d = (lit_dec == 8'd0) ? mtdd_pkg::PH_BLANK1 : mtdd_pkg::PH_ONES;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= mtdd_pkg::PH_ONES;
			lit_q      <= mtdd_pkg::ON_TIME_RST;
			blank_q    <= mtdd_pkg::OFF_TIME_RST;
			ones_q     <= 4'd0;
			tens_q     <= 4'd0;
			hund_q     <= 4'd0;
			last_seg_q <= 7'd0;
		end else if (step) begin
			unique case (item.command)
				mtdd_pkg::CMD_TICK: begin
					phase_q <= phase_d;
					if (is_lit) begin
						lit_q      <= lit_dec;
						last_seg_q <= seg_new;
						if (lit_dec == 8'd0) begin
							blank_q <= off_time;
						end
					end else begin
						blank_q <= blank_dec;
						if (blank_dec == 8'd0) begin
							lit_q <= on_time;
						end
					end
				end
				mtdd_pkg::CMD_LOAD: begin
					ones_q <= ones_full[3:0];
					tens_q <= tens_full[3:0];
					hund_q <= conv_hund;
				end
				mtdd_pkg::CMD_RESTART: begin
					ones_q  <= item.ones_digit;
					tens_q  <= item.tens_digit;
					hund_q  <= item.hundreds_digit;
					phase_q <= mtdd_pkg::PH_ONES;
					lit_q   <= on_time;
					blank_q <= off_time;
				end
				mtdd_pkg::CMD_NONE: begin
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/multiplexed_three_digit_display_unit.sv =====
// A tick beat's result passes through the input register, then the result
// register; load, restart and none beats give no result.
// Throughput: one beat per cycle, set by the single scan update in the second
// stage; a waiting result stalls only beats that would produce another one.
// Reset (asynchronous, active low): ones digit lit, counters 9 and 1, digits
// and held segment pattern zero, on_time 9, off_time 1, both stages empty.
module multiplexed_three_digit_display_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  logic [9:0] reading,
	input  logic [3:0] ones_digit,
	input  logic [3:0] tens_digit,
	input  logic [3:0] hundreds_digit,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] digit_select,
	output logic [6:0] segments,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0]      on_time_q;
	logic [7:0]      off_time_q;
	logic            s1_valid_q;
	mtdd_pkg::item_t item_s1;
	logic            out_valid_q;
	mtdd_pkg::res_t  res_q;
	mtdd_pkg::res_t  scan_res;

	logic [41:0]     volt_prod;
	logic            produces;
	logic            s1_go;
	logic            in_fire;

	assign volt_prod = 42'(reading) * 42'(mtdd_pkg::VOLT_MUL);

	assign produces = (item_s1.command == mtdd_pkg::CMD_TICK);
	// Beats that produce nothing never wait for the output register.
	assign s1_go    = s1_valid_q && (!produces || !out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_go;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_time_q  <= mtdd_pkg::ON_TIME_RST;
			off_time_q <= mtdd_pkg::OFF_TIME_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mtdd_pkg::REG_ON_TIME:  on_time_q  <= cfg_data;
				mtdd_pkg::REG_OFF_TIME: off_time_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.command        <= mtdd_pkg::cmd_t'(command);
			item_s1.volts          <= volt_prod[mtdd_pkg::VOLT_SHIFT +: 10];
			item_s1.ones_digit     <= ones_digit;
			item_s1.tens_digit     <= tens_digit;
			item_s1.hundreds_digit <= hundreds_digit;
		end
	end

	mtdd_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (s1_go),
		.item     (item_s1),
		.on_time  (on_time_q),
		.off_time (off_time_q),
		.result   (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && produces) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && produces) begin
			res_q <= scan_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign digit_select = res_q.digit_select;
	assign segments     = res_q.segments;

`ifndef NO_ASSERTIONS
	// A beat held in the first stage is never dropped.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_go |=> s1_valid_q)
		else $error("first-stage beat lost while stalled");

	// A non-tick beat never raises a fresh result.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && !produces && (!out_valid_q || out_ready) |=> !out_valid_q)
		else $error("result raised by a beat that produces none");

	// An empty first stage always takes a new beat.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> in_ready)
		else $error("input stalled with an empty first stage");

	// The scaled reading stays within three decimal digits.
	a_volts_range: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> item_s1.volts <= 10'd999)
		else $error("volts value above 999");
`endif

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mtdd_pkg::*;

	// Own model of the scan, the digit store and the held segment pattern.
	class display_scoreboard;
		res_t        pending_q[$];
		logic [7:0]  on_time;
		logic [7:0]  off_time;
		logic [2:0]  phase;
		logic [7:0]  lit_count;
		logic [7:0]  blank_count;
		logic [3:0]  digit_store[3];
		logic [6:0]  last_seg;
		logic [6:0]  glyph[10];
		int unsigned mismatches;

		function new();
			glyph = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};
			on_time = ON_TIME_RST;
			off_time = OFF_TIME_RST;
			phase = PH_ONES;
			lit_count = ON_TIME_RST;
			blank_count = OFF_TIME_RST;
			digit_store = '{4'd0, 4'd0, 4'd0};
			last_seg = 7'd0;
			mismatches = 0;
		endfunction

		function void set_register(logic [0:0] idx, logic [7:0] val);
			if (idx == REG_ON_TIME)
				on_time = val;
			else
				off_time = val;
		endfunction

		function int unsigned pending_count();
			return pending_q.size();
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		// Applies one accepted input beat and queues the display output it causes.
		task note_beat(cmd_t c, logic [9:0] rd, logic [3:0] o, logic [3:0] t, logic [3:0] h);
			int unsigned volts;
			logic [1:0]  which;
			logic [3:0]  d;
			res_t        exp_res;
			case (c)
				CMD_LOAD: begin
					volts = (int'(rd) * 97665) / 100000;
					digit_store[0] = 4'(volts % 10);
					digit_store[1] = 4'((volts / 10) % 10);
					digit_store[2] = 4'((volts / 100) % 10);
				end
				CMD_RESTART: begin
					digit_store[0] = o;
					digit_store[1] = t;
					digit_store[2] = h;
					phase = PH_ONES;
					lit_count = on_time;
					blank_count = off_time;
				end
				CMD_TICK: begin
					if (phase > PH_BLANK3)
						phase = PH_ONES;
					if (phase[0] == 1'b0) begin
						which = phase[2:1];
						d = digit_store[which];
						lit_count = lit_count - 8'd1;
						if (lit_count == 8'd0) begin
							phase = phase + 3'd1;
							blank_count = off_time;
						end
						// A digit above nine leaves the bus showing the previous pattern.
						if (d < 4'd10)
							last_seg = glyph[d];
						exp_res.digit_select = which + 2'd1;
					end else begin
						blank_count = blank_count - 8'd1;
						if (blank_count == 8'd0) begin
							phase = (phase == PH_BLANK3) ? 3'(PH_ONES) : phase + 3'd1;
							lit_count = on_time;
						end
						exp_res.digit_select = 2'd0;
					end
					exp_res.segments = last_seg;
					pending_q.push_back(exp_res);
				end
				default: ;
			endcase
		endtask

		task check_result(logic [1:0] sel, logic [6:0] seg);
			res_t exp_res;
			if (pending_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result sel=%0d seg=%02h", sel, seg));
			end else begin
				exp_res = pending_q.pop_front();
				if (sel !== exp_res.digit_select)
					report_mismatch($sformatf("digit_select got %0d, want %0d",
						sel, exp_res.digit_select));
				if (seg !== exp_res.segments)
					report_mismatch($sformatf("segments got %02h, want %02h",
						seg, exp_res.segments));
			end
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] command;
	logic [9:0] reading;
	logic [3:0] ones_digit;
	logic [3:0] tens_digit;
	logic [3:0] hundreds_digit;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] digit_select;
	logic [6:0] segments;
	logic       cfg_we;
	logic [0:0] cfg_index;
	logic [7:0] cfg_data;

	display_scoreboard sb;
	int unsigned       send_gap_pct;
	int unsigned       stall_pct;

	multiplexed_three_digit_display_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.reading        (reading),
		.ones_digit     (ones_digit),
		.tens_digit     (tens_digit),
		.hundreds_digit (hundreds_digit),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.digit_select   (digit_select),
		.segments       (segments),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(digit_select, segments);
	end

	// Presents one beat and returns at the edge where it is taken.
	task automatic send_beat(cmd_t c, logic [9:0] rd, logic [3:0] o, logic [3:0] t,
			logic [3:0] h);
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		reading <= rd;
		ones_digit <= o;
		tens_digit <= t;
		hundreds_digit <= h;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		sb.note_beat(c, rd, o, t, h);
	endtask

	task automatic tick_n(int unsigned n);
		repeat (n)
			send_beat(CMD_TICK, 10'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
	endtask

	// Holds the sender off until every display output has come back, then lets the
	// pipeline empty of load and restart beats as well.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timing(logic [0:0] idx, logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_register(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(int unsigned n, int unsigned restart_pm);
		int unsigned done;
		int unsigned roll;
		cmd_t        c;
		logic [9:0]  rd;
		logic [3:0]  dg[3];
		done = 0;
		while (done < n) begin
			roll = $urandom_range(999);
			if (roll < restart_pm)
				c = CMD_RESTART;
			else if (roll < restart_pm + 90)
				c = CMD_LOAD;
			else if (roll < restart_pm + 110)
				c = CMD_NONE;
			else
				c = CMD_TICK;
			case ($urandom_range(9))
				0: rd = 10'd0;
				1: rd = 10'd1023;
				default: rd = 10'($urandom_range(1023));
			endcase
			// Mostly proper decimal digits, now and then one above nine.
			foreach (dg[k])
				dg[k] = ($urandom_range(99) < 85) ? 4'($urandom_range(9))
					: 4'($urandom_range(15, 10));
			send_beat(c, rd, dg[0], dg[1], dg[2]);
			if (c != CMD_NONE)
				done++;
		end
	endtask

	task automatic run_phase(logic [7:0] on_t, logic [7:0] off_t, int unsigned gap,
			int unsigned stall, int unsigned n, int unsigned restart_pm);
		drain();
		write_timing(REG_ON_TIME, on_t);
		write_timing(REG_OFF_TIME, off_t);
		send_gap_pct = gap;
		stall_pct = stall;
		run_random(n, restart_pm);
	endtask

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_TICK;
		reading = 10'd0;
		ones_digit = 4'd0;
		tens_digit = 4'd0;
		hundreds_digit = 4'd0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ON_TIME;
		cfg_data = 8'd0;
		send_gap_pct = 0;
		stall_pct = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed beats at the reset timing.
		tick_n(2);
		send_beat(CMD_LOAD, 10'd1023, 4'd0, 4'd0, 4'd0);
		tick_n(3);
		send_beat(CMD_LOAD, 10'd0, 4'd15, 4'd15, 4'd15);
		send_beat(CMD_RESTART, 10'd1023, 4'd15, 4'd10, 4'd12);
		tick_n(2);
		send_beat(CMD_RESTART, 10'd0, 4'd1, 4'd2, 4'd3);
		send_beat(CMD_NONE, 10'd1023, 4'd15, 4'd15, 4'd15);
		tick_n(1);
		send_beat(CMD_LOAD, 10'd512, 4'd0, 4'd0, 4'd0);
		tick_n(1);
		send_beat(CMD_LOAD, 10'd1, 4'd0, 4'd0, 4'd0);
		tick_n(1);
		send_beat(CMD_RESTART, 10'd0, 4'd0, 4'd9, 4'd8);
		tick_n(3);

		run_phase(8'd2, 8'd1, 0, 0, 250, 40);
		run_phase(8'd1, 8'd1, 65, 0, 300, 30);
		run_phase(8'd255, 8'd255, 0, 65, 350, 0);
		// A zero count wraps, so these phases each last 256 ticks.
		run_phase(8'd0, 8'd1, 31, 31, 300, 0);
		run_phase(8'd3, 8'd0, 0, 0, 300, 0);
		run_phase(8'($urandom_range(8, 1)), 8'($urandom_range(8, 1)), 31, 31, 200, 20);
		drain();
		run_random(250, 20);

		drain();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_count() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
